>>> rtl/waveform_column_line_generator_defines.svh
// assertion macros for the waveform column line generator
// used by the top level; expects clk and arst_n in the enclosing scope
`ifndef WAVEFORM_COLUMN_LINE_GENERATOR_DEFINES_SVH
`define WAVEFORM_COLUMN_LINE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define WVCL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
`define WVCL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
`else
`define WVCL_ASSERT(lbl, prop)
`define WVCL_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

>>> rtl/wvcl_pkg.sv
// shared types and constants for the waveform column line generator
// no dependencies
`timescale 1ns / 1ps

package wvcl_pkg;

	localparam int SAMPLE_W            = 32;
	localparam int SAMPLE_BITS_DEFAULT = 32;
	localparam int IDX_W               = 24;
	localparam int COL_W               = 12;
	localparam int ROW_W               = 11;
	localparam int MAG_W               = 32;
	localparam int CFG_IDX_W           = 3;
	localparam int CFG_DATA_W          = 32;

	localparam int QUO_W     = 12;
	localparam int COL_NUM_W = 38;
	localparam int COL_DEN_W = 25;
	localparam int LEN_NUM_W = 45;
	localparam int LEN_DEN_W = 33;

	localparam logic [COL_W-1:0] COL_SAT = {COL_W{1'b1}};

	localparam logic [IDX_W-1:0]  NUM_SAMPLES_RST  = IDX_W'(1);
	localparam logic [COL_W-1:0]  SCREEN_WIDTH_RST = COL_W'(640);
	localparam logic [ROW_W-1:0]  HALF_HEIGHT_RST  = ROW_W'(240);
	localparam logic [ROW_W-1:0]  FULL_LEN_RST     = ROW_W'(200);
	localparam logic [MAG_W-1:0]  MAX_ABS_RST      = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_SAMPLES,
		REG_SCREEN_WIDTH,
		REG_HALF_HEIGHT,
		REG_FULL_LEN,
		REG_MAX_ABS
	} wvcl_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0] num_samples;
		logic [COL_W-1:0] screen_width;
		logic [ROW_W-1:0] half_height;
		logic [ROW_W-1:0] full_len;
		logic [MAG_W-1:0] max_abs;
	} wvcl_cfg_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} wvcl_div_stat_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_CHK,
		DIV_RUN
	} wvcl_div_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} wvcl_state_t;

endpackage

>>> rtl/wvcl_if.sv
// sample and segment channel interfaces, valid/ready handshake
// depends on wvcl_pkg
`timescale 1ns / 1ps

interface wvcl_in_if import wvcl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                frame_start;

	modport source (output valid, output sample, output frame_start, input ready);
	modport sink (input valid, input sample, input frame_start, output ready);
endinterface

interface wvcl_out_if import wvcl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column;
	logic [ROW_W-1:0] start_row;
	logic [ROW_W-1:0] length;
	logic             step_down;

	modport source (output valid, output column, output start_row, output length,
		output step_down, input ready);
	modport sink (input valid, input column, input start_row, input length,
		input step_down, output ready);
endinterface

>>> rtl/wvcl_cfg.sv
// configuration register file with plain write port
// depends on wvcl_pkg
`timescale 1ns / 1ps

module wvcl_cfg import wvcl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output wvcl_cfg_t             cfg
);

	wvcl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_samples  <= NUM_SAMPLES_RST;
			cfg_q.screen_width <= SCREEN_WIDTH_RST;
			cfg_q.half_height  <= HALF_HEIGHT_RST;
			cfg_q.full_len     <= FULL_LEN_RST;
			cfg_q.max_abs      <= MAX_ABS_RST;
		end else if (cfg_we) begin
			case (wvcl_reg_t'(cfg_idx))
				REG_NUM_SAMPLES: begin
					cfg_q.num_samples <= cfg_wdata[IDX_W-1:0];
				end
				REG_SCREEN_WIDTH: begin
					cfg_q.screen_width <= cfg_wdata[COL_W-1:0];
				end
				REG_HALF_HEIGHT: begin
					cfg_q.half_height <= cfg_wdata[ROW_W-1:0];
				end
				REG_FULL_LEN: begin
					cfg_q.full_len <= cfg_wdata[ROW_W-1:0];
				end
				REG_MAX_ABS: begin
					cfg_q.max_abs <= cfg_wdata[MAG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/wvcl_serial_div.sv
// bit-serial restoring divider with quotient overflow check
// depends on wvcl_pkg
`timescale 1ns / 1ps

module wvcl_serial_div import wvcl_pkg::*; #(
	parameter int NUM_W = COL_NUM_W,
	parameter int DEN_W = COL_DEN_W,
	parameter int Q_W   = QUO_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output wvcl_div_stat_t   stat
);

	localparam int HI_W  = NUM_W - Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	wvcl_div_state_t  state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [HI_W-1:0]  rem_q;
	logic [Q_W-1:0]   lo_q;
	logic [DEN_W-1:0] den_q;
	logic             ovf_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// one quotient bit per cycle
	assign trial = {rem_q[DEN_W-1:0], lo_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					state_d = DIV_CHK;
				end
			end
			DIV_CHK: begin
				state_d = DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DIV_CHK) begin
				cnt_q <= CNT_W'(Q_W);
			end else if (state_q == DIV_RUN) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == DIV_IDLE) begin
			rem_q <= num[NUM_W-1:Q_W];
			lo_q  <= num[Q_W-1:0];
			den_q <= den;
		end else if (state_q == DIV_CHK) begin
			ovf_q <= rem_q >= HI_W'(den_q);
		end else if (state_q == DIV_RUN) begin
			rem_q <= ge ? HI_W'(diff[DEN_W-1:0]) : HI_W'(trial[DEN_W-1:0]);
			lo_q  <= {lo_q[Q_W-2:0], ge};
		end
	end

	assign quo       = lo_q;
	assign stat.done = state_q == DIV_IDLE;
	assign stat.ovf  = ovf_q;

endmodule

>>> rtl/waveform_column_line_generator.sv
// Waveform column line generator: takes one signed sample per request, maps its running
// index to a screen column and, when the sample extends the column's min/max envelope or
// opens a new column, emits one vertical segment (column, start row, length, direction).
// Each sample passes through the states in order: multiply, operand load, divide, where two
// bit-serial restoring dividers (column and length) run side by side, each making an overflow
// check and then a 12-bit quotient; finish, which updates the envelope; and idle, which takes
// the next request. No new sample is accepted until the last one is through.
// A finished segment waits in an output register while the next sample
// is worked on; only a second segment arriving before the first is taken adds stall cycles.
// Depends on wvcl_pkg, wvcl_if, wvcl_cfg, wvcl_serial_div and the assertion macro header.
`timescale 1ns / 1ps
`include "waveform_column_line_generator_defines.svh"

module waveform_column_line_generator import wvcl_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wvcl_in_if.sink               samples,
	wvcl_out_if.source            segments
);

	wvcl_cfg_t cfg;

	wvcl_state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] s_q;
	logic signed [SAMPLE_BITS-1:0] col_max_q;
	logic signed [SAMPLE_BITS-1:0] col_min_q;
	logic [IDX_W-1:0]              idx_q;
	logic [IDX_W-1:0]              sample_index_q;
	logic [COL_W-1:0]              last_column_q;
	logic [IDX_W+COL_W-1:0]        prod_col_q;
	logic [MAG_W+ROW_W-1:0]        prod_len_q;

	logic [SAMPLE_BITS-1:0] mag;
	logic [IDX_W-1:0]       n_eff;
	logic [IDX_W-1:0]       idx_use;
	logic [COL_NUM_W-1:0]   col_num;
	logic [COL_DEN_W-1:0]   col_den;
	logic [LEN_NUM_W-1:0]   len_num;
	logic [LEN_DEN_W-1:0]   len_den;
	logic [QUO_W-1:0]       col_quo;
	logic [QUO_W-1:0]       len_quo;
	wvcl_div_stat_t         col_stat;
	wvcl_div_stat_t         len_stat;

	logic             accept;
	logic             div_start;
	logic             fin_go;
	logic             draw;
	logic             same_col;
	logic [COL_W-1:0] col_val;
	logic [ROW_W-1:0] len_val;

	logic             out_valid_q;
	logic [COL_W-1:0] out_column_q;
	logic [ROW_W-1:0] out_row_q;
	logic [ROW_W-1:0] out_len_q;
	logic             out_down_q;

	wvcl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign accept  = samples.valid && samples.ready;
	assign idx_use = samples.frame_start ? '0 : sample_index_q;

	// two's complement magnitude, most negative value maps to 2^(SAMPLE_BITS-1)
	assign mag   = s_q[SAMPLE_BITS-1] ? (~s_q + SAMPLE_BITS'(1)) : s_q;
	assign n_eff = (cfg.num_samples == '0) ? IDX_W'(1) : cfg.num_samples;

	assign col_num = {prod_col_q, 1'b0} + COL_NUM_W'(n_eff);
	assign col_den = {n_eff, 1'b0};
	assign len_num = {prod_len_q, 1'b0} + LEN_NUM_W'(cfg.max_abs);
	assign len_den = {cfg.max_abs, 1'b0};

	wvcl_serial_div #(
		.NUM_W (COL_NUM_W),
		.DEN_W (COL_DEN_W),
		.Q_W   (QUO_W)
	) u_col_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (col_num),
		.den    (col_den),
		.quo    (col_quo),
		.stat   (col_stat)
	);

	wvcl_serial_div #(
		.NUM_W (LEN_NUM_W),
		.DEN_W (LEN_DEN_W),
		.Q_W   (QUO_W)
	) u_len_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (len_num),
		.den    (len_den),
		.quo    (len_quo),
		.stat   (len_stat)
	);

	// quotient results with saturation
	always_comb begin
		col_val = col_stat.ovf ? COL_SAT : col_quo[COL_W-1:0];
		if (cfg.max_abs == '0) begin
			len_val = '0;
		end else if (len_stat.ovf || (len_quo > QUO_W'(cfg.full_len))) begin
			len_val = cfg.full_len;
		end else begin
			len_val = len_quo[ROW_W-1:0];
		end
	end

	assign same_col = col_val == last_column_q;

	always_comb begin
		draw = 1'b1;
		if (same_col) begin
			draw = (s_q >= col_max_q) || (s_q < col_min_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (samples.valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (col_stat.done && len_stat.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				fin_go = !draw || !out_valid_q || segments.ready;
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign samples.ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_index_q <= '0;
			last_column_q  <= '0;
			col_max_q      <= '0;
			col_min_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sample_index_q <= idx_use + IDX_W'(1);
				if (samples.frame_start) begin
					last_column_q <= '0;
					col_max_q     <= '0;
					col_min_q     <= '0;
				end
			end
			// envelope update once per sample
			if (fin_go) begin
				if (!same_col) begin
					col_max_q     <= '0;
					col_min_q     <= '0;
					last_column_q <= col_val;
				end else if (s_q >= col_max_q) begin
					col_max_q <= s_q;
				end else if (s_q < col_min_q) begin
					col_min_q <= s_q;
				end
			end
			if (fin_go && draw) begin
				out_valid_q <= 1'b1;
			end else if (segments.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_q   <= samples.sample[SAMPLE_BITS-1:0];
			idx_q <= idx_use;
		end
		if (state_q == ST_MUL) begin
			prod_col_q <= idx_q * cfg.screen_width;
			prod_len_q <= MAG_W'(mag) * cfg.full_len;
		end
		if (fin_go && draw) begin
			out_column_q <= col_val;
			out_row_q    <= cfg.half_height;
			out_len_q    <= len_val;
			out_down_q   <= s_q[SAMPLE_BITS-1];
		end
	end

	assign segments.valid     = out_valid_q;
	assign segments.column    = out_column_q;
	assign segments.start_row = out_row_q;
	assign segments.length    = out_len_q;
	assign segments.step_down = out_down_q;

	`WVCL_ASSERT(div_in_step, col_stat.done == len_stat.done)
	`WVCL_ASSERT(env_order, col_max_q >= col_min_q)
	`WVCL_ASSERT_IMP(len_bounded, state_q == ST_FIN, len_val <= cfg.full_len)
	`WVCL_ASSERT_IMP(out_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN)

endmodule
